FILE: sv/slt_pkg.sv
// Shared types, codes and the operator decoder for the line tokenizer.
package slt_pkg;

   localparam logic [3:0] KIND_WORD    = 4'd0;
   localparam logic [3:0] KIND_AND     = 4'd1;
   localparam logic [3:0] KIND_OR      = 4'd2;
   localparam logic [3:0] KIND_SEMI    = 4'd3;
   localparam logic [3:0] KIND_EQ      = 4'd4;
   localparam logic [3:0] KIND_OPEN2   = 4'd5;
   localparam logic [3:0] KIND_CLOSE2  = 4'd6;
   localparam logic [3:0] KIND_PLUS    = 4'd7;
   localparam logic [3:0] KIND_MINUS   = 4'd8;
   localparam logic [3:0] KIND_STAR    = 4'd9;
   localparam logic [3:0] KIND_SLASH   = 4'd10;
   localparam logic [3:0] KIND_PERCENT = 4'd11;
   localparam logic [3:0] KIND_END     = 4'd12;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_BAR     = 8'h7C;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_EQ      = 8'h3D;
   localparam logic [7:0] CHAR_OPEN    = 8'h28;
   localparam logic [7:0] CHAR_CLOSE   = 8'h29;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] start;
      logic [7:0] length;
      logic [5:0] index;
      logic       overflow;
      logic       line_done;
   } token_type;

   // Results of one byte, slot 0 first.
   typedef struct packed {
      token_type [MAX_RESULTS-1:0] slot;
      logic [1:0]                  count;
   } batch_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [1:0] width;
   } op_type;

   // Classify a byte against its lookahead; width zero means not an operator.
   function automatic op_type op_decode(input logic [7:0] cc, input logic [7:0] nx);
      op_type op;
      op = '{kind: KIND_WORD, width: 2'd0};
      case (cc)
         CHAR_AMP:     if (nx == CHAR_AMP)   op = '{kind: KIND_AND,    width: 2'd2};
         CHAR_BAR:     if (nx == CHAR_BAR)   op = '{kind: KIND_OR,     width: 2'd2};
         CHAR_OPEN:    if (nx == CHAR_OPEN)  op = '{kind: KIND_OPEN2,  width: 2'd2};
         CHAR_CLOSE:   if (nx == CHAR_CLOSE) op = '{kind: KIND_CLOSE2, width: 2'd2};
         CHAR_SEMI:    op = '{kind: KIND_SEMI,    width: 2'd1};
         CHAR_EQ:      op = '{kind: KIND_EQ,      width: 2'd1};
         CHAR_PLUS:    op = '{kind: KIND_PLUS,    width: 2'd1};
         CHAR_MINUS:   op = '{kind: KIND_MINUS,   width: 2'd1};
         CHAR_STAR:    op = '{kind: KIND_STAR,    width: 2'd1};
         CHAR_SLASH:   op = '{kind: KIND_SLASH,   width: 2'd1};
         CHAR_PERCENT: op = '{kind: KIND_PERCENT, width: 2'd1};
         default:      op = '{kind: KIND_WORD,    width: 2'd0};
      endcase
      return op;
   endfunction

endpackage

FILE: sv/shell_line_tokenizer_core.sv
// Shell command line tokenizer: top level with input register and result channel.
//
// Usage: bytes of a command line enter on the req_ stream, one byte per item;
// a zero byte ends the line. Each byte is classified when the next one arrives.
// Results leave on the rsp_ stream: words as start and length, operators
// (&& || ; = (( )) + - * / %) as kind and position, and at the end of each
// line an end marker (rsp_tlast high) whose length field is the token count.
// A byte is held in the input register, its results go to the result buffer and
// from there one at a time to the output register. Throughput: one byte per
// cycle while each byte yields at most one result and the receiver keeps up; a
// byte with more results makes the input wait on the single result port.
// When the receiver stalls, the output register holds its item, the result
// buffer fills and req_tready drops; no item is lost.
// Reset clears all line state, the buffer and the output valid; the first byte
// after reset starts a new line at position 0. A nonzero byte that would land at
// position LINE_BYTES-1 or later, and tokens past TOKEN_LIMIT, are dropped and set
// the overflow flag.
module shell_line_tokenizer_core #(
   parameter int LINE_BYTES  = 256,
   parameter int TOKEN_LIMIT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] token_kind, [11:4] token_start,
                                    // [19:12] token_length, [25:20] token_index,
                                    // [26] overflow, [31:27] zero
   output logic        rsp_tlast    // line_done
);
   import slt_pkg::*;

   logic [7:0] byte_ff, byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       can_load;
   logic       step_fire;
   batch_type  batch;
   token_type  out_item;

   // Step the held byte once the result buffer can take its results.
   assign step_fire  = byte_valid_ff && can_load;
   assign req_tready = !byte_valid_ff || step_fire;

   assign byte_in       = (req_tvalid && req_tready) ? req_tdata : byte_ff;
   assign byte_valid_in = (req_tvalid && req_tready) || (byte_valid_ff && !step_fire);

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
      end
   end

   slt_step #(
      .LINE_BYTES  (LINE_BYTES),
      .TOKEN_LIMIT (TOKEN_LIMIT)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (step_fire),
      .char_in (byte_ff),
      .batch   (batch)
   );

   slt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (step_fire),
      .batch     (batch),
      .can_load  (can_load),
      .out_item  (out_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {5'd0, out_item.overflow, out_item.index, out_item.length,
                       out_item.start, out_item.kind};
   assign rsp_tlast = out_item.line_done;

   // A full batch is word, operator and end marker, so its last slot ends the line.
   a_third_is_end: assert property (@(posedge clock) disable iff (reset)
      step_fire && batch.count == 2'd3 |-> batch.slot[2].line_done)
      else $error("third result of a byte is not the end marker");

   // The end marker is always the last result of its byte.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      step_fire && batch.count >= 2'd2 |-> !batch.slot[0].line_done)
      else $error("end marker followed by another result");

   // tlast marks exactly the end-marker kind.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tdata[3:0] == KIND_END))
      else $error("tlast disagrees with token kind");

endmodule

FILE: sv/slt_step.sv
// Per-byte tokenizer step: line state registers and the result decode.
module slt_step #(
   parameter int LINE_BYTES  = 256,
   parameter int TOKEN_LIMIT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        char_in,
   output slt_pkg::batch_type batch
);
   import slt_pkg::*;

   localparam int POS_W = $clog2(LINE_BYTES + 1);
   localparam int CNT_W = $clog2(TOKEN_LIMIT + 1);
   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(LINE_BYTES - 1);
   localparam logic [CNT_W-1:0] TOKEN_MAX = CNT_W'(TOKEN_LIMIT);

   logic [7:0]       held_byte_ff, held_byte_in;
   logic             held_valid_ff, held_valid_in;
   logic             skip_ff, skip_in;
   logic [POS_W-1:0] line_pos_ff, line_pos_in;
   logic [POS_W-1:0] word_begin_ff, word_begin_in;
   logic [CNT_W-1:0] tokens_ff, tokens_in;
   logic             overflow_ff, overflow_in;

   logic [POS_W-1:0] q;
   op_type           op;
   logic [1:0]       n;

   always_comb begin
      q             = line_pos_ff + POS_W'(held_valid_ff);
      op            = op_decode(held_byte_ff, char_in);
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      skip_in       = skip_ff;
      line_pos_in   = line_pos_ff;
      word_begin_in = word_begin_ff;
      tokens_in     = tokens_ff;
      overflow_in   = overflow_ff;
      batch         = '0;
      n             = 2'd0;

      if (char_in != CHAR_NUL && q >= LAST_POS) begin
         // drop the byte, line is full
         overflow_in = 1'b1;
      end else begin
         if (held_valid_ff && skip_ff) begin
            skip_in = 1'b0;
         end else if (held_valid_ff && (held_byte_ff == CHAR_SPACE || op.width != 2'd0)) begin
            // close the current word at the held byte
            if (line_pos_ff > word_begin_in) begin
               if (tokens_in >= TOKEN_MAX) begin
                  overflow_in = 1'b1;
               end else begin
                  batch.slot[n] = '{kind: KIND_WORD, start: 8'(word_begin_in),
                                    length: 8'(line_pos_ff - word_begin_in),
                                    index: 6'(tokens_in), overflow: overflow_in,
                                    line_done: 1'b0};
                  n         = n + 2'd1;
                  tokens_in = tokens_in + CNT_W'(1);
               end
            end
            word_begin_in = line_pos_ff + POS_W'(1);
            if (op.width != 2'd0) begin
               if (tokens_in >= TOKEN_MAX) begin
                  overflow_in = 1'b1;
               end else begin
                  batch.slot[n] = '{kind: op.kind, start: 8'(line_pos_ff),
                                    length: 8'(op.width), index: 6'(tokens_in),
                                    overflow: overflow_in, line_done: 1'b0};
                  n         = n + 2'd1;
                  tokens_in = tokens_in + CNT_W'(1);
               end
               word_begin_in = line_pos_ff + POS_W'(op.width);
               skip_in       = (op.width == 2'd2);
            end
         end

         if (char_in == CHAR_NUL) begin
            // close the last word, then the end marker
            if (q > word_begin_in) begin
               if (tokens_in >= TOKEN_MAX) begin
                  overflow_in = 1'b1;
               end else begin
                  batch.slot[n] = '{kind: KIND_WORD, start: 8'(word_begin_in),
                                    length: 8'(q - word_begin_in),
                                    index: 6'(tokens_in), overflow: overflow_in,
                                    line_done: 1'b0};
                  n         = n + 2'd1;
                  tokens_in = tokens_in + CNT_W'(1);
               end
            end
            batch.slot[n] = '{kind: KIND_END, start: 8'(q),
                              length: (32'(tokens_in) > 32'd255) ? 8'hFF : 8'(tokens_in),
                              index: 6'd0, overflow: overflow_in, line_done: 1'b1};
            n             = n + 2'd1;
            held_byte_in  = '0;
            held_valid_in = 1'b0;
            skip_in       = 1'b0;
            line_pos_in   = '0;
            word_begin_in = '0;
            tokens_in     = '0;
            overflow_in   = 1'b0;
         end else begin
            held_byte_in  = char_in;
            held_valid_in = 1'b1;
            line_pos_in   = q;
         end
      end
      batch.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         skip_ff       <= 1'b0;
         line_pos_ff   <= '0;
         word_begin_ff <= '0;
         tokens_ff     <= '0;
         overflow_ff   <= 1'b0;
      end else if (fire) begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         skip_ff       <= skip_in;
         line_pos_ff   <= line_pos_in;
         word_begin_ff <= word_begin_in;
         tokens_ff     <= tokens_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

FILE: sv/slt_queue.sv
// Result buffer: holds one byte's results and feeds them to the output register.
module slt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  slt_pkg::batch_type batch,
   output logic               can_load,
   output slt_pkg::token_type out_item,
   output logic               out_valid,
   input  logic               out_ready
);
   import slt_pkg::*;

   token_type [MAX_RESULTS-1:0] pend_ff, pend_in;
   logic [1:0]                  count_ff, count_in;
   token_type                   out_ff, out_in;
   logic                        valid_ff, valid_in;
   logic                        out_free;
   logic                        move;

   assign out_free = !valid_ff || out_ready;
   assign move     = (count_ff != 2'd0) && out_free;
   assign can_load = (count_ff == 2'd0) || (count_ff == 2'd1 && out_free);

   always_comb begin
      pend_in  = pend_ff;
      count_in = count_ff;
      out_in   = out_ff;
      valid_in = valid_ff && !out_ready;
      if (move) begin
         // advance the head into the output register
         out_in     = pend_ff[0];
         valid_in   = 1'b1;
         pend_in[0] = pend_ff[1];
         pend_in[1] = pend_ff[2];
         count_in   = count_ff - 2'd1;
      end
      if (load) begin
         pend_in  = batch.slot;
         count_in = batch.count;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      if (reset) begin
         count_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign out_item  = out_ff;
   assign out_valid = valid_ff;

endmodule
